FILE: hdl/pfla_pkg.sv
package pfla_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int ADDR_W    = $clog2(MAX_PAGES);
  // page count and list head hold 0..MAX_PAGES
  localparam int CNT_W     = ADDR_W + 1;
  localparam int IDX_W     = 12;
  // scan position: one more bit so that index +/- 1 cannot wrap
  localparam int POS_W     = IDX_W + 1;

  localparam logic [CNT_W-1:0] HEAD_NIL = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0] PAGE_MAX = CNT_W'(MAX_PAGES);

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_DISPOSE = 3'd1,
    OP_GET     = 3'd2,
    OP_NEXT    = 3'd3,
    OP_PREV    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_EOF     = 3'd2,
    ST_INVALID = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_CHECK,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [IDX_W-1:0] page_index;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] page_number;
  } out_res_t;

endpackage

FILE: hdl/page_free_list_allocator.sv
// Channel   Ports                          Direction  Moves
// request   start, busy, in_req            in         op, page_index
// result    out_valid, out_res             out        status, page_number
// config    cfg_we, cfg_wdata              in         file_open
//
// One request at a time. A rejected request or an append is answered
// straight from idle; allocate from the free list, dispose and get-this
// make one mark or link read first; get-next/get-prev test one used mark
// per cycle through the single read port of the mark memory.
// Synchronous reset; no clearing pass: page_count bounds every mark read.
// busy is high while a request is in work; the receiver cannot stall.
module page_free_list_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pfla_pkg::in_req_t  in_req,
  output logic               out_valid,
  output pfla_pkg::out_res_t out_res,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  import pfla_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  head_r, head_nxt;     // free list head, HEAD_NIL when empty
  logic [CNT_W-1:0]  count_r, count_nxt;   // pages in the file
  logic              file_open_r;

  // request held while in work
  logic [2:0]              op_r, op_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;

  // result stage
  logic     out_valid_r;
  out_res_t out_res_r;
  logic     done;
  out_res_t res;

  // memory ports
  logic              used_we, used_wdata, used_re, used_rdata;
  logic [ADDR_W-1:0] used_waddr, used_raddr;
  logic              link_we, link_re;
  logic [ADDR_W-1:0] link_waddr, link_raddr;
  logic [CNT_W-1:0]  link_wdata, link_rdata;

  logic                    accept;
  logic signed [POS_W-1:0] idx_s, pos_start, pos_adv;
  logic                    start_ok, adv_ok, head_empty, store_full;

  function automatic logic in_rng(input logic signed [POS_W-1:0] p,
                                  input logic [CNT_W-1:0] cnt);
    in_rng = (p >= 0) && (p < $signed(POS_W'(cnt)));
  endfunction

  pfla_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (used_re),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  pfla_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PAGES)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // scan start: get-next looks at index+1, get-prev at index-1
  assign idx_s     = POS_W'(in_req.page_index);
  assign pos_start = (in_req.op == OP_NEXT) ? idx_s + POS_W'(1) :
                     (in_req.op == OP_PREV) ? idx_s - POS_W'(1) : idx_s;
  assign pos_adv   = (op_r == OP_PREV) ? pos_r - POS_W'(1) : pos_r + POS_W'(1);
  assign start_ok  = in_rng(pos_start, count_r);
  assign adv_ok    = in_rng(pos_adv, count_r);
  assign head_empty = (head_r == HEAD_NIL);
  assign store_full = (count_r >= PAGE_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && file_open_r) begin
          case (in_req.op) inside
            OP_ALLOC:           if (!head_empty) state_nxt = S_ALLOC;
            OP_DISPOSE, OP_GET: if (start_ok) state_nxt = S_CHECK;
            OP_NEXT, OP_PREV:   if (start_ok) state_nxt = S_SCAN;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC: state_nxt = S_IDLE;
      S_CHECK: state_nxt = S_IDLE;
      S_SCAN: begin
        if (used_rdata || !adv_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and result
  always_comb begin
    done        = 1'b0;
    res         = '{status: ST_INVALID, page_number: '0};
    used_we     = 1'b0;
    used_waddr  = pos_r[ADDR_W-1:0];
    used_wdata  = 1'b0;
    used_re     = 1'b0;
    used_raddr  = pos_start[ADDR_W-1:0];
    link_we     = 1'b0;
    link_waddr  = pos_r[ADDR_W-1:0];
    link_wdata  = head_r;
    link_re     = 1'b0;
    link_raddr  = head_r[ADDR_W-1:0];
    head_nxt    = head_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_req.op;
          pos_nxt = pos_start;
          if (!file_open_r) begin
            done       = 1'b1;
            res.status = ST_CLOSED;
          end else begin
            case (in_req.op) inside
              OP_ALLOC: begin
                if (!head_empty) begin
                  link_re = 1'b1;
                end else if (store_full) begin
                  done       = 1'b1;
                  res.status = ST_FULL;
                end else begin
                  // append a fresh page at the end of the file
                  used_we         = 1'b1;
                  used_waddr      = count_r[ADDR_W-1:0];
                  used_wdata      = 1'b1;
                  count_nxt       = count_r + CNT_W'(1);
                  done            = 1'b1;
                  res.status      = ST_OK;
                  res.page_number = count_r[ADDR_W-1:0];
                end
              end
              OP_DISPOSE, OP_GET, OP_NEXT, OP_PREV: begin
                if (start_ok) begin
                  used_re = 1'b1;
                end else begin
                  done       = 1'b1;
                  res.status = ST_EOF;
                end
              end
              default: begin
                done       = 1'b1;
                res.status = ST_INVALID;
              end
            endcase
          end
        end
      end
      S_ALLOC: begin
        // pop the head; a stale link past the end closes the list
        head_nxt        = (link_rdata > HEAD_NIL) ? HEAD_NIL : link_rdata;
        used_we         = 1'b1;
        used_waddr      = head_r[ADDR_W-1:0];
        used_wdata      = 1'b1;
        done            = 1'b1;
        res.status      = ST_OK;
        res.page_number = head_r[ADDR_W-1:0];
      end
      S_CHECK: begin
        done = 1'b1;
        if (!used_rdata) begin
          res.status = ST_INVALID;
        end else if (op_r == OP_DISPOSE) begin
          link_we    = 1'b1;
          head_nxt   = CNT_W'(pos_r[ADDR_W-1:0]);
          used_we    = 1'b1;
          res.status = ST_OK;
        end else begin
          res.status      = ST_OK;
          res.page_number = pos_r[ADDR_W-1:0];
        end
      end
      S_SCAN: begin
        if (used_rdata) begin
          done            = 1'b1;
          res.status      = ST_OK;
          res.page_number = pos_r[ADDR_W-1:0];
        end else if (adv_ok) begin
          pos_nxt    = pos_adv;
          used_re    = 1'b1;
          used_raddr = pos_adv[ADDR_W-1:0];
        end else begin
          done       = 1'b1;
          res.status = ST_EOF;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= HEAD_NIL;
      count_r     <= '0;
      file_open_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= done;
      if (cfg_we) begin
        file_open_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a result only follows an accepted request or work in progress
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request");

  // list head and page count never pass the store size
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= HEAD_NIL) && (count_r <= PAGE_MAX))
    else $error("head or page count out of bounds");

  // a scan only looks at pages inside the file
  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> in_rng(pos_r, count_r))
    else $error("scan position outside the file");

  // count grows only by one, and only on an allocate that appends
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1)) && $past(head_r == HEAD_NIL))
    else $error("page count changed unexpectedly");

endmodule

FILE: hdl/pfla_ram.sv
module pfla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: test/page_free_list_allocator_checker.sv
`timescale 1ns / 1ps

module page_free_list_allocator_checker
  import pfla_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_res_t out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output int       fails,
  output int       pending
);

  // Shadow copy of the page store bookkeeping
  bit               mark_used [MAX_PAGES];
  logic [CNT_W-1:0] link_next [MAX_PAGES];
  logic [CNT_W-1:0] head_ptr;
  logic [CNT_W-1:0] page_total;
  bit               open_flag;

  out_res_t         awaited_results [$];
  int               fail_total = 0;
  int               queued = 0;

  assign fails   = fail_total;
  assign pending = queued;

  function automatic bit in_file(int p);
    return p >= 0 && p < int'(page_total);
  endfunction

  // Applies one request to the shadow state and returns its result
  function automatic out_res_t apply_page_op(in_req_t req);
    out_res_t res;
    int       idx;
    int       p;
    int       dir;
    bit       found;
    res.status      = ST_INVALID;
    res.page_number = '0;
    idx = int'($signed(req.page_index));
    if (!open_flag) begin
      res.status = ST_CLOSED;
    end else begin
      case (req.op)
        OP_ALLOC: begin
          if (head_ptr < HEAD_NIL) begin
            p = int'(head_ptr);
            head_ptr = link_next[p];
            mark_used[p] = 1'b1;
            res.status      = ST_OK;
            res.page_number = ADDR_W'(p);
          end else if (page_total >= PAGE_MAX) begin
            res.status = ST_FULL;
          end else begin
            p = int'(page_total);
            page_total = page_total + 1'b1;
            mark_used[p] = 1'b1;
            res.status      = ST_OK;
            res.page_number = ADDR_W'(p);
          end
        end
        OP_DISPOSE, OP_GET: begin
          if (!in_file(idx)) begin
            res.status = ST_EOF;
          end else if (!mark_used[idx]) begin
            res.status = ST_INVALID;
          end else begin
            res.status = ST_OK;
            if (req.op == OP_GET) begin
              res.page_number = ADDR_W'(idx);
            end else begin
              link_next[idx] = head_ptr;
              head_ptr = CNT_W'(idx);
              mark_used[idx] = 1'b0;
            end
          end
        end
        OP_NEXT, OP_PREV: begin
          dir   = (req.op == OP_NEXT) ? 1 : -1;
          p     = idx + dir;
          found = 1'b0;
          res.status = ST_EOF;
          while (!found && in_file(p)) begin
            if (mark_used[p]) begin
              found = 1'b1;
              res.status      = ST_OK;
              res.page_number = ADDR_W'(p);
            end else begin
              p += dir;
            end
          end
        end
        default: res.status = ST_INVALID;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_res_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < MAX_PAGES; i++) mark_used[i] = 1'b0;
      head_ptr   = HEAD_NIL;
      page_total = '0;
      open_flag  = 1'b1;
      awaited_results.delete();
    end else begin
      // result first: it belongs to an earlier request
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d page_number %0d",
                 out_res.status, out_res.page_number);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (out_res.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_res.status);
            errs++;
          end
          if (out_res.page_number !== want.page_number) begin
            $error("page_number mismatch: expected %0d, actual %0d",
                   want.page_number, out_res.page_number);
            errs++;
          end
        end
      end
      // a request taken at the same edge as a register write sees the old value
      if (start && !busy) awaited_results.push_back(apply_page_op(in_req));
      if (cfg_we) open_flag = cfg_wdata;
    end
    fail_total <= fail_total + errs;
    queued     <= awaited_results.size();
  end

endmodule

FILE: test/page_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module page_free_list_allocator_tb;
  import pfla_pkg::*;

  // Longest quiet stretch of a correct run is one full scan plus a short
  // sender gap; this is well beyond that.
  localparam int QUIET_LIMIT  = 20000;
  // Settle time after the last result, to catch stray strobes
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1100;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;
  logic     cfg_we;
  logic     cfg_wdata;

  int       fails;
  int       pending;
  int       quiet_cycles = 0;
  // Upper bound on the page count, used to aim indexes at live pages
  int       pages_hint = 0;
  bit       file_is_open = 1'b1;
  bit       full_seen = 1'b0;
  int       random_sent = 0;

  page_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  page_free_list_allocator_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stimulus keeps allocating until the store reports full at least once
  always @(posedge clk) begin
    if (out_valid && out_res.status == ST_FULL) full_seen <= 1'b1;
  end

  // Watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drop start and hold off for as long as n says
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every outstanding request has produced its result.
  // pending is a registered count, so let it update before looking at it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle
  task automatic set_open(input bit v);
    drain();
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    file_is_open = v;
  endtask

  // Present one request and return at the edge that accepts it; start is
  // left high so back-to-back requests need no extra assignment.
  task automatic issue(input logic [2:0] op, input int idx);
    in_req_t r;
    r.op         = op;
    r.page_index = IDX_W'(idx);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_ALLOC && file_is_open && pages_hint < MAX_PAGES) pages_hint++;
  endtask

  // Random request: allocation weight in percent, the rest split over
  // dispose / get / scans with a trickle of undefined opcodes.
  function automatic in_req_t pick_req(input int alloc_w);
    in_req_t r;
    int      roll;
    int      idx;
    roll = $urandom_range(99);
    if (roll < alloc_w) begin
      r.op = OP_ALLOC;
    end else begin
      roll = $urandom_range(99);
      if (roll < 3)       r.op = 3'($urandom_range(7, int'(OP_PREV) + 1));
      else if (roll < 33) r.op = OP_DISPOSE;
      else if (roll < 58) r.op = OP_GET;
      else if (roll < 79) r.op = OP_NEXT;
      else                r.op = OP_PREV;
    end
    roll = $urandom_range(99);
    if (roll < 65)      idx = int'($urandom_range(pages_hint));
    else if (roll < 78) idx = $urandom_range(1) ? -1 : pages_hint;   // scan from an end
    else if (roll < 90) idx = ($urandom_range(1) ? -2 : pages_hint - 1)
                              + int'($urandom_range(3));
    else                idx = int'($urandom_range(4095)) - 2048;     // whole 12-bit field
    r.page_index = IDX_W'(idx);
    return r;
  endfunction

  // Each cycle the sender could present a request it idles with
  // probability idle_pct percent.
  task automatic run_mix(input int count, input int idle_pct, input int alloc_w,
                         input bit hold_offs);
    in_req_t r;
    for (int i = 0; i < count; i++) begin
      while (int'($urandom_range(99)) < idle_pct) pause(1);
      r = pick_req(alloc_w);
      issue(r.op, int'($signed(r.page_index)));
      random_sent++;
      if (hold_offs && $urandom_range(99) < 3) drain();
    end
  endtask

  initial begin
    int n;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: empty file, everything out of range
    issue(OP_NEXT, -1);
    issue(OP_PREV, 0);
    issue(OP_DISPOSE, 0);
    issue(OP_GET, 0);
    // grow to three pages
    issue(OP_ALLOC, 0);
    issue(OP_ALLOC, 0);
    issue(OP_ALLOC, 0);
    // free page 1, then a second dispose of it must be refused
    issue(OP_DISPOSE, 1);
    issue(OP_DISPOSE, 1);
    issue(OP_GET, 1);
    // scans step over the freed page; -1 / page count start at the ends
    issue(OP_NEXT, 0);
    issue(OP_PREV, 2);
    issue(OP_NEXT, -1);
    issue(OP_PREV, 3);
    // starts beyond the ends, and the field extremes
    issue(OP_NEXT, -2);
    issue(OP_PREV, 4);
    issue(OP_NEXT, -2048);
    issue(OP_PREV, 2047);
    issue(OP_GET, -2048);
    issue(OP_DISPOSE, 2047);
    // index equal to the page count is just past the end
    issue(OP_GET, 3);
    // undefined opcodes
    for (int k = int'(OP_PREV) + 1; k < 8; k++) issue(3'(k), 0);
    // allocate reuses the freed page
    issue(OP_ALLOC, 0);

    // closed file: every defined opcode is refused
    set_open(1'b0);
    for (int k = int'(OP_ALLOC); k <= int'(OP_PREV); k++) issue(3'(k), 1);
    set_open(1'b1);

    // --- random, light sender gaps, with occasional full hold-offs
    run_mix(150, 19, 70, 1'b1);

    set_open(1'b0);
    run_mix(8, 0, 40, 1'b0);
    set_open(1'b1);

    // --- random, heavy sender gaps
    run_mix(120, 82, 70, 1'b0);

    // --- back to back: fill the store until it reports full
    n = 0;
    while (!full_seen && n < 1200) begin
      issue(OP_ALLOC, 0);
      n++;
    end
    random_sent += n;

    // closed while full, then churn a full store: dispose, reuse, refill
    set_open(1'b0);
    run_mix(6, 0, 50, 1'b0);
    set_open(1'b1);
    n = RANDOM_ITEMS - random_sent;
    run_mix((n > 60) ? n : 60, 0, 35, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
